// ----- rtl/swcm_pkg.sv -----
// shared constants and types for the sliding window composition match block
package swcm_pkg;

    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int MAX_QUERY_DEF     = 256;

    localparam int RESIDUE_W    = 8;
    localparam int SHARED_OUT_W = 9;
    localparam int LENGTH_OUT_W = 9;
    localparam int SIM_W        = 17;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    localparam int USER_OPCODE = 0;
    localparam int USER_FIRST  = 1;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_HIT   = 1'b1;

    typedef struct packed {
        logic clr;
        logic wr;
    } t_hist_ctl;

endpackage

// ----- rtl/sliding_window_composition_match.sv -----
// top level of the sliding window composition match block
// Query residues (tuser opcode 0) build the query histogram, a transfer with
// the first flag starting a new query; each query residue empties the hit
// window. Hit residues (opcode 1) slide a window of query length over the hit
// stream and, once the window is full, give one result per residue: the
// histogram intersection, the query length and their ratio as an unsigned
// q1.16 fraction rounded down. A hit residue is dropped while the query is
// empty. Otherwise it goes through the histogram read-modify-write, after a
// second one for the leaving residue once the window is full; a residue that
// completes a full window then runs the 17 one-bit steps of the divider, waits
// for it to finish and loads the output register. The input is not ready
// while an item is in work; a finished result waits in the output register
// and does not hold off the next input transfer, but the next result waits
// for that register to be free.
module sliding_window_composition_match
    import swcm_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int MAX_QUERY     = MAX_QUERY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // residue
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,  // opcode, first
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // shared_count, window_length,
                                                    // similarity_q16, zero pad
);

    localparam int BW = $clog2(ALPHABET_SIZE);
    localparam int LW = $clog2(MAX_QUERY + 1);
    localparam int PW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int PAD_W = OUT_TDATA_W - SHARED_OUT_W - LENGTH_OUT_W - SIM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_QRD  = 4'd1;
    localparam logic [3:0] S_QWR  = 4'd2;
    localparam logic [3:0] S_HIT  = 4'd3;
    localparam logic [3:0] S_XRD  = 4'd4;
    localparam logic [3:0] S_XWR  = 4'd5;
    localparam logic [3:0] S_BRD  = 4'd6;
    localparam logic [3:0] S_BWR  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    function automatic logic [BW-1:0] f_bin(input logic [RESIDUE_W-1:0] b);
        if ({1'b0, b} >= (RESIDUE_W + 1)'(ALPHABET_SIZE)) begin
            return BW'(ALPHABET_SIZE - 1);
        end else begin
            return BW'(b);
        end
    endfunction

    logic [3:0]           r_state, n_state;
    logic [RESIDUE_W-1:0] r_byte;
    logic [BW-1:0]        r_bin;
    logic [BW-1:0]        r_x, n_x;
    logic [LW-1:0]        r_qlen, n_qlen;
    logic [LW-1:0]        r_fill, n_fill;
    logic [PW-1:0]        r_pos, n_pos;
    logic [LW-1:0]        r_shared, n_shared;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [RESIDUE_W-1:0] r_ring [MAX_QUERY];
    logic [RESIDUE_W-1:0] r_ring_q;
    logic                 ring_wr;

    t_hist_ctl     q_ctl, w_ctl;
    logic [BW-1:0] hist_rd_addr, hist_wr_addr;
    logic [LW-1:0] q_wr_data, w_wr_data;
    logic [LW-1:0] q_rd_data, w_rd_data;

    logic             div_start, div_done;
    logic [SIM_W-1:0] div_quo;

    logic          in_xfer;
    logic          out_load;
    logic [LW-1:0] pos_inc;
    logic [PW-1:0] pos_next;
    logic          full;
    logic [BW-1:0] x_comb;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign pos_inc  = LW'(r_pos) + 1'b1;
    assign pos_next = (pos_inc >= r_qlen) ? '0 : PW'(pos_inc);
    assign full     = r_fill >= r_qlen;
    assign x_comb   = f_bin(r_ring_q);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    assign hist_rd_addr = (r_state == S_XRD) ? x_comb : r_bin;
    assign hist_wr_addr = (r_state == S_XWR) ? r_x : r_bin;

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_qlen    = r_qlen;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_shared  = r_shared;
        q_ctl     = '0;
        w_ctl     = '0;
        q_wr_data = q_rd_data + 1'b1;
        w_wr_data = w_rd_data + 1'b1;
        ring_wr   = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_s_axis_tuser[USER_OPCODE] == OP_QUERY) begin
                        w_ctl.clr = 1'b1;
                        n_fill    = '0;
                        n_pos     = '0;
                        n_shared  = '0;
                        if (i_s_axis_tuser[USER_FIRST]) begin
                            q_ctl.clr = 1'b1;
                            n_qlen    = '0;
                        end
                        n_state = S_QRD;
                    end else begin
                        n_state = S_HIT;
                    end
                end
            end
            S_QRD: begin
                n_state = (r_qlen < LW'(MAX_QUERY)) ? S_QWR : S_IDLE;
            end
            S_QWR: begin
                q_ctl.wr = 1'b1;
                n_qlen   = r_qlen + 1'b1;
                n_state  = S_IDLE;
            end
            S_HIT: begin
                if (r_qlen == '0) begin
                    n_state = S_IDLE;
                end else if (full) begin
                    n_state = S_XRD;
                end else begin
                    ring_wr = 1'b1;
                    n_fill  = r_fill + 1'b1;
                    n_pos   = pos_next;
                    n_state = S_BRD;
                end
            end
            S_XRD: begin
                n_x     = x_comb;
                n_state = S_XWR;
            end
            S_XWR: begin
                w_wr_data = w_rd_data - 1'b1;
                if (w_rd_data != '0) begin
                    w_ctl.wr = 1'b1;
                    if ((w_wr_data < q_rd_data) && (r_shared != '0)) begin
                        n_shared = r_shared - 1'b1;
                    end
                end
                ring_wr = 1'b1;
                n_pos   = pos_next;
                n_state = S_BRD;
            end
            S_BRD: begin
                n_state = S_BWR;
            end
            S_BWR: begin
                w_ctl.wr = 1'b1;
                if (w_rd_data < q_rd_data) begin
                    n_shared = r_shared + 1'b1;
                end
                if (full) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qlen      <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_shared    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_qlen   <= n_qlen;
            r_fill   <= n_fill;
            r_pos    <= n_pos;
            r_shared <= n_shared;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        if (in_xfer) begin
            r_byte <= i_s_axis_tdata[RESIDUE_W-1:0];
            r_bin  <= f_bin(i_s_axis_tdata[RESIDUE_W-1:0]);
        end
        if (out_load) begin
            r_out_data <= {PAD_W'(0), div_quo, LENGTH_OUT_W'(r_qlen),
                           SHARED_OUT_W'(r_shared)};
        end
    end

    // window ring
    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[r_pos] <= r_byte;
        end
        r_ring_q <= r_ring[r_pos];
    end

    swcm_hist #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (BW),
        .CW    (LW)
    ) u_query_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_rd_addr (hist_rd_addr),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (q_wr_data),
        .o_rd_data (q_rd_data)
    );

    swcm_hist #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (BW),
        .CW    (LW)
    ) u_window_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (hist_rd_addr),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // the divider takes the intersection as it is updated for the entering residue
    swcm_div #(
        .W (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_shared),
        .i_divisor  (r_qlen),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/swcm_hist.sv -----
// residue histogram memory with per-bin valid bits and registered read
module swcm_hist
    import swcm_pkg::*;
#(
    parameter int DEPTH = ALPHABET_SIZE_DEF,
    parameter int AW    = $clog2(ALPHABET_SIZE_DEF),
    parameter int CW    = $clog2(MAX_QUERY_DEF + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_hist_ctl     i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [CW-1:0] i_wr_data,
    output logic [CW-1:0] o_rd_data
);

    logic [CW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [CW-1:0]    r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- rtl/swcm_div.sv -----
// restoring divider, one quotient bit per cycle, for the q1.16 similarity
module swcm_div
    import swcm_pkg::*;
#(
    parameter int W = $clog2(MAX_QUERY_DEF + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_dividend,
    input  logic [W-1:0]     i_divisor,
    output logic             o_done,
    output logic [SIM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SIM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W:0]       r_rem;
    logic [SIM_W-1:0] r_quo;
    logic             trial;
    logic [W:0]       rem_sub;

    assign trial   = r_rem >= {1'b0, i_divisor};
    assign rem_sub = trial ? (r_rem - {1'b0, i_divisor}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SIM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
        end else if (r_busy) begin
            r_rem <= {rem_sub[W-1:0], 1'b0};
            r_quo <= {r_quo[SIM_W-2:0], trial};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/swcm_chk.sv -----
// port-level checker for the sliding window composition match block, with its bind
module swcm_chk
    import swcm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << 16;

    logic [SHARED_OUT_W-1:0] shared_f;
    logic [LENGTH_OUT_W-1:0] length_f;
    logic [SIM_W-1:0]        sim_f;

    assign shared_f = o_m_axis_tdata[8:0];
    assign length_f = o_m_axis_tdata[17:9];
    assign sim_f    = o_m_axis_tdata[34:18];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result transfer changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an input transfer");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> sim_f <= SIM_ONE)
        else $error("similarity above one");

    a_sim_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && sim_f == SIM_ONE |-> shared_f == length_f)
        else $error("similarity one without a full match");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=> i_s_axis_tvalid
            && $stable(i_s_axis_tdata) && $stable(i_s_axis_tuser))
        else $error("waiting input transfer changed");

endmodule

bind sliding_window_composition_match swcm_chk u_swcm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
